### rtl/wqrc_pkg.sv
// Shared types, codes and defaults of the retry counter table.
package wqrc_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 16;
   localparam int COUNT_BITS_DEFAULT    = 8;

   localparam int ACTION_BITS  = 3;
   localparam int TID_BITS     = 4;
   localparam int SEQ_BITS     = 12;
   localparam int FRAG_BITS    = 4;
   localparam int LENGTH_BITS  = 16;
   localparam int KEY_BITS     = TID_BITS + SEQ_BITS + FRAG_BITS;
   localparam int CW_BITS      = 2;
   localparam int REPORT_BITS  = 8;
   localparam int STATION_BITS = 8;
   localparam int LIMIT_BITS   = 8;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_DATA_FAIL  = 3'd0,
      ACT_RTS_FAIL   = 3'd1,
      ACT_ACK        = 3'd2,
      ACT_DROP       = 3'd3,
      ACT_CTS        = 3'd4,
      ACT_BLOCKACK   = 3'd5,
      ACT_MCAST_SENT = 3'd6,
      ACT_QUERY      = 3'd7
   } action_type;

   typedef enum logic [CW_BITS-1:0] {
      CW_NONE      = 2'd0,
      CW_INCREMENT = 2'd1,
      CW_RESET     = 2'd2
   } cw_cmd_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_RTS_THRESHOLD     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SHORT_RETRY_LIMIT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LONG_RETRY_LIMIT  = 2'd2;

   localparam logic [LENGTH_BITS-1:0] RTS_THRESHOLD_RESET     = 16'd2346;
   localparam logic [LIMIT_BITS-1:0]  SHORT_RETRY_LIMIT_RESET = 8'd7;
   localparam logic [LIMIT_BITS-1:0]  LONG_RETRY_LIMIT_RESET  = 8'd4;

endpackage

### rtl/wqrc_req_if.sv
// Request channel: one MAC event word.
interface wqrc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [wqrc_pkg::ACTION_BITS-1:0]     action;
   logic [wqrc_pkg::TID_BITS-1:0]        tid;
   logic [wqrc_pkg::SEQ_BITS-1:0]        seq_num;
   logic [wqrc_pkg::FRAG_BITS-1:0]       frag_num;
   logic [wqrc_pkg::LENGTH_BITS-1:0]     frame_length;

   modport source (output valid, action, tid, seq_num, frag_num, frame_length,
                   input ready);
   modport sink   (input valid, action, tid, seq_num, frag_num, frame_length,
                   output ready);
endinterface

### rtl/wqrc_rsp_if.sv
// Response channel: one result word per event.
interface wqrc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [wqrc_pkg::CW_BITS-1:0]         cw_command;
   logic [wqrc_pkg::REPORT_BITS-1:0]     retry_count;
   logic                                 limit_reached;
   logic                                 rts_limit_reached;
   logic                                 entry_missing;
   logic                                 table_full;
   logic [wqrc_pkg::STATION_BITS-1:0]    station_short_count;
   logic [wqrc_pkg::STATION_BITS-1:0]    station_long_count;

   modport source (output valid, cw_command, retry_count, limit_reached,
                   rts_limit_reached, entry_missing, table_full,
                   station_short_count, station_long_count,
                   input ready);
   modport sink   (input valid, cw_command, retry_count, limit_reached,
                   rts_limit_reached, entry_missing, table_full,
                   station_short_count, station_long_count,
                   output ready);
endinterface

### rtl/wqrc_cell.sv
// One table slot in the rotating ring; the top two bits are the class valid bits.
module wqrc_cell #(
   parameter int SLOT_BITS = 2 + wqrc_pkg::KEY_BITS + 2 * wqrc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  logic [SLOT_BITS-1:0] slot_in,
   output logic [SLOT_BITS-1:0] slot_out
);

   logic [1:0]           valid_ff;
   logic [1:0]           valid_in;
   logic [SLOT_BITS-3:0] body_ff;
   logic [SLOT_BITS-3:0] body_in;

   always_comb begin
      valid_in = shift ? slot_in[SLOT_BITS-1 -: 2] : valid_ff;
      body_in  = shift ? slot_in[SLOT_BITS-3:0]    : body_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 2'b00;
      end else begin
         valid_ff <= valid_in;
      end
      body_ff <= body_in;
   end

   assign slot_out = {valid_ff, body_ff};

endmodule

### rtl/wqrc_ctrl.sv
// Sequencer, head update logic, station counters and configuration registers.
module wqrc_ctrl #(
   parameter int TABLE_ENTRIES = wqrc_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int COUNT_BITS    = wqrc_pkg::COUNT_BITS_DEFAULT,
   parameter int SLOT_BITS     = 2 + wqrc_pkg::KEY_BITS + 2 * COUNT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   wqrc_req_if.sink                            req_port,
   wqrc_rsp_if.source                          rsp_port,
   input  logic                                csr_write_enable,
   input  logic [wqrc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [wqrc_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic [SLOT_BITS-1:0]                ring_tail,
   output logic [SLOT_BITS-1:0]                ring_head,
   output logic                                ring_shift
);

   localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_BITS-1:0] LAST_STEP = IDX_BITS'(TABLE_ENTRIES - 1);
   localparam int EXT_BITS = (COUNT_BITS > 8) ? COUNT_BITS : 8;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   typedef struct packed {
      logic                               sv;
      logic                               lv;
      logic [wqrc_pkg::TID_BITS-1:0]      tid;
      logic [wqrc_pkg::SEQ_BITS-1:0]      seq;
      logic [wqrc_pkg::FRAG_BITS-1:0]     frag;
      logic [COUNT_BITS-1:0]              sc;
      logic [COUNT_BITS-1:0]              lc;
   } slot_type;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_INSERT, S_DONE} state_type;

   function automatic logic [7:0] sat8(input logic [COUNT_BITS-1:0] c);
      logic [EXT_BITS-1:0] e;
      e = EXT_BITS'(c);
      return (e > EXT_BITS'(255)) ? 8'hFF : e[7:0];
   endfunction

   function automatic logic at_limit(input logic [COUNT_BITS-1:0] c,
                                     input logic [7:0] l);
      return EXT_BITS'(c) >= EXT_BITS'(l);
   endfunction

   state_type               state_ff, state_in;
   logic [IDX_BITS-1:0]     step_ff, step_in;
   wqrc_pkg::action_type    act_ff, act_in;
   logic [wqrc_pkg::TID_BITS-1:0]  tid_ff, tid_in;
   logic [wqrc_pkg::SEQ_BITS-1:0]  seq_ff, seq_in;
   logic [wqrc_pkg::FRAG_BITS-1:0] frag_ff, frag_in;
   logic                    lng_ff, lng_in;
   wqrc_pkg::cw_cmd_type    cw_ff, cw_in;
   logic                    hit_ff, hit_in;
   logic                    free_ff, free_in;
   logic                    ins_ff, ins_in;
   logic [7:0]              res_cnt_ff, res_cnt_in;
   logic                    res_lim_ff, res_lim_in;
   logic                    res_rlim_ff, res_rlim_in;
   logic                    res_miss_ff, res_miss_in;
   logic                    res_full_ff, res_full_in;
   logic [7:0]              ssrc_ff, ssrc_in;
   logic [7:0]              slrc_ff, slrc_in;
   logic [15:0]             thr_ff, thr_in;
   logic [7:0]              slim_ff, slim_in;
   logic [7:0]              llim_ff, llim_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   wqrc_pkg::cw_cmd_type    out_cw_ff, out_cw_in;
   logic [7:0]              out_cnt_ff, out_cnt_in;
   logic                    out_lim_ff, out_lim_in;
   logic                    out_rlim_ff, out_rlim_in;
   logic                    out_miss_ff, out_miss_in;
   logic                    out_full_ff, out_full_in;
   logic [7:0]              out_ssrc_ff, out_ssrc_in;
   logic [7:0]              out_slrc_ff, out_slrc_in;

   slot_type                cur, upd, ins, wr;
   logic                    match, free, cap, is_fail;
   logic                    wr_cv, wr_present;
   logic [COUNT_BITS-1:0]   wr_c;
   logic [7:0]              wr_l;
   logic [7:0]              cap_cnt;
   logic                    cap_lim, cap_rlim, cap_miss;
   wqrc_pkg::action_type    req_act;
   logic                    req_lng;
   logic [7:0]              ssrc_bump, slrc_bump;

   // head cell: the slot leaving the tail is examined and written back to the front
   always_comb begin
      cur   = slot_type'(ring_tail);
      match = (cur.sv || cur.lv) && cur.tid == tid_ff && cur.seq == seq_ff
              && cur.frag == frag_ff;
      free  = !cur.sv && !cur.lv;
      is_fail = act_ff == wqrc_pkg::ACT_DATA_FAIL || act_ff == wqrc_pkg::ACT_RTS_FAIL;

      upd = cur;
      case (act_ff) inside
         wqrc_pkg::ACT_DATA_FAIL, wqrc_pkg::ACT_RTS_FAIL: begin
            if (lng_ff) begin
               if (!cur.lv) begin
                  upd.lv = 1'b1;
                  upd.lc = COUNT_ONE;
               end else if (cur.lc != COUNT_MAX) begin
                  upd.lc = cur.lc + COUNT_ONE;
               end
            end else begin
               if (!cur.sv) begin
                  upd.sv = 1'b1;
                  upd.sc = COUNT_ONE;
               end else if (cur.sc != COUNT_MAX) begin
                  upd.sc = cur.sc + COUNT_ONE;
               end
            end
         end
         wqrc_pkg::ACT_ACK, wqrc_pkg::ACT_DROP: begin
            if (lng_ff) begin
               upd.lv = 1'b0;
               upd.lc = '0;
            end else begin
               upd.sv = 1'b0;
               upd.sc = '0;
            end
         end
         default: ;
      endcase

      ins.sv   = !lng_ff;
      ins.lv   = lng_ff;
      ins.tid  = tid_ff;
      ins.seq  = seq_ff;
      ins.frag = frag_ff;
      ins.sc   = lng_ff ? '0 : COUNT_ONE;
      ins.lc   = lng_ff ? COUNT_ONE : '0;

      cap = 1'b0;
      wr  = cur;
      if (state_ff == S_SCAN && match) begin
         cap = 1'b1;
         wr  = upd;
      end else if (state_ff == S_INSERT && !ins_ff && free) begin
         cap = 1'b1;
         wr  = ins;
      end

      wr_present = wr.sv || wr.lv;
      wr_cv      = lng_ff ? wr.lv : wr.sv;
      wr_c       = lng_ff ? wr.lc : wr.sc;
      wr_l       = lng_ff ? llim_ff : slim_ff;
      if (wr_present) begin
         cap_cnt  = wr_cv ? sat8(wr_c) : 8'd0;
         cap_lim  = wr_cv && at_limit(wr_c, wr_l);
         cap_rlim = wr.sv && at_limit(wr.sc, slim_ff);
         cap_miss = act_ff == wqrc_pkg::ACT_QUERY && !wr_cv;
      end else begin
         cap_cnt  = 8'd0;
         cap_lim  = 1'b0;
         cap_rlim = 1'b0;
         cap_miss = act_ff == wqrc_pkg::ACT_QUERY;
      end
   end

   always_comb begin
      req_act   = wqrc_pkg::action_type'(req_port.action);
      req_lng   = req_act != wqrc_pkg::ACT_RTS_FAIL && req_port.frame_length >= thr_ff;
      ssrc_bump = (ssrc_ff == 8'hFF) ? ssrc_ff : ssrc_ff + 8'd1;
      slrc_bump = (slrc_ff == 8'hFF) ? slrc_ff : slrc_ff + 8'd1;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      act_in       = act_ff;
      tid_in       = tid_ff;
      seq_in       = seq_ff;
      frag_in      = frag_ff;
      lng_in       = lng_ff;
      cw_in        = cw_ff;
      hit_in       = hit_ff;
      free_in      = free_ff;
      ins_in       = ins_ff;
      res_cnt_in   = res_cnt_ff;
      res_lim_in   = res_lim_ff;
      res_rlim_in  = res_rlim_ff;
      res_miss_in  = res_miss_ff;
      res_full_in  = res_full_ff;
      ssrc_in      = ssrc_ff;
      slrc_in      = slrc_ff;
      thr_in       = thr_ff;
      slim_in      = slim_ff;
      llim_in      = llim_ff;
      rsp_valid_in = rsp_valid_ff;
      out_cw_in    = out_cw_ff;
      out_cnt_in   = out_cnt_ff;
      out_lim_in   = out_lim_ff;
      out_rlim_in  = out_rlim_ff;
      out_miss_in  = out_miss_ff;
      out_full_in  = out_full_ff;
      out_ssrc_in  = out_ssrc_ff;
      out_slrc_in  = out_slrc_ff;
      ring_shift   = 1'b0;
      ring_head    = wr;

      if (csr_write_enable) begin
         unique case (csr_index)
            wqrc_pkg::CSR_RTS_THRESHOLD:     thr_in  = csr_write_data;
            wqrc_pkg::CSR_SHORT_RETRY_LIMIT: slim_in = csr_write_data[7:0];
            wqrc_pkg::CSR_LONG_RETRY_LIMIT:  llim_in = csr_write_data[7:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cap) begin
         res_cnt_in  = cap_cnt;
         res_lim_in  = cap_lim;
         res_rlim_in = cap_rlim;
         res_miss_in = cap_miss;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_port.valid) begin
               act_in      = req_act;
               tid_in      = req_port.tid;
               seq_in      = req_port.seq_num;
               frag_in     = req_port.frag_num;
               lng_in      = req_lng;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               ins_in      = 1'b0;
               step_in     = '0;
               res_cnt_in  = 8'd0;
               res_lim_in  = 1'b0;
               res_rlim_in = 1'b0;
               res_miss_in = req_act == wqrc_pkg::ACT_QUERY;
               res_full_in = 1'b0;
               cw_in       = wqrc_pkg::CW_NONE;
               case (req_act) inside
                  wqrc_pkg::ACT_DATA_FAIL, wqrc_pkg::ACT_RTS_FAIL: begin
                     if (req_lng) begin
                        slrc_in = slrc_bump;
                        cw_in   = (slrc_bump == llim_ff) ? wqrc_pkg::CW_RESET
                                                         : wqrc_pkg::CW_INCREMENT;
                     end else begin
                        ssrc_in = ssrc_bump;
                        cw_in   = (ssrc_bump == slim_ff) ? wqrc_pkg::CW_RESET
                                                         : wqrc_pkg::CW_INCREMENT;
                     end
                  end
                  wqrc_pkg::ACT_ACK: begin
                     if (req_lng) begin
                        slrc_in = 8'd0;
                     end else begin
                        ssrc_in = 8'd0;
                     end
                     cw_in = wqrc_pkg::CW_RESET;
                  end
                  wqrc_pkg::ACT_CTS, wqrc_pkg::ACT_BLOCKACK: begin
                     ssrc_in = 8'd0;
                  end
                  wqrc_pkg::ACT_MCAST_SENT: begin
                     ssrc_in = 8'd0;
                     slrc_in = 8'd0;
                  end
                  default: ;
               endcase
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ring_shift = 1'b1;
            step_in    = step_ff + IDX_BITS'(1);
            if (match) begin
               hit_in = 1'b1;
            end
            if (free) begin
               free_in = 1'b1;
            end
            if (step_ff == LAST_STEP) begin
               step_in = '0;
               if (!(hit_ff || match) && is_fail) begin
                  if (free_ff || free) begin
                     state_in = S_INSERT;
                  end else begin
                     res_full_in = 1'b1;
                     state_in    = S_DONE;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_INSERT: begin
            ring_shift = 1'b1;
            step_in    = step_ff + IDX_BITS'(1);
            if (cap) begin
               ins_in = 1'b1;
            end
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               out_cw_in    = cw_ff;
               out_cnt_in   = res_cnt_ff;
               out_lim_in   = res_lim_ff;
               out_rlim_in  = res_rlim_ff;
               out_miss_in  = res_miss_ff;
               out_full_in  = res_full_ff;
               out_ssrc_in  = ssrc_ff;
               out_slrc_in  = slrc_ff;
               state_in     = S_IDLE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         ins_ff       <= 1'b0;
         ssrc_ff      <= 8'd0;
         slrc_ff      <= 8'd0;
         thr_ff       <= wqrc_pkg::RTS_THRESHOLD_RESET;
         slim_ff      <= wqrc_pkg::SHORT_RETRY_LIMIT_RESET;
         llim_ff      <= wqrc_pkg::LONG_RETRY_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         ins_ff       <= ins_in;
         ssrc_ff      <= ssrc_in;
         slrc_ff      <= slrc_in;
         thr_ff       <= thr_in;
         slim_ff      <= slim_in;
         llim_ff      <= llim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      tid_ff      <= tid_in;
      seq_ff      <= seq_in;
      frag_ff     <= frag_in;
      lng_ff      <= lng_in;
      cw_ff       <= cw_in;
      res_cnt_ff  <= res_cnt_in;
      res_lim_ff  <= res_lim_in;
      res_rlim_ff <= res_rlim_in;
      res_miss_ff <= res_miss_in;
      res_full_ff <= res_full_in;
      out_cw_ff   <= out_cw_in;
      out_cnt_ff  <= out_cnt_in;
      out_lim_ff  <= out_lim_in;
      out_rlim_ff <= out_rlim_in;
      out_miss_ff <= out_miss_in;
      out_full_ff <= out_full_in;
      out_ssrc_ff <= out_ssrc_in;
      out_slrc_ff <= out_slrc_in;
   end

   assign req_port.ready               = state_ff == S_IDLE;
   assign rsp_port.valid               = rsp_valid_ff;
   assign rsp_port.cw_command          = out_cw_ff;
   assign rsp_port.retry_count         = out_cnt_ff;
   assign rsp_port.limit_reached       = out_lim_ff;
   assign rsp_port.rts_limit_reached   = out_rlim_ff;
   assign rsp_port.entry_missing       = out_miss_ff;
   assign rsp_port.table_full          = out_full_ff;
   assign rsp_port.station_short_count = out_ssrc_ff;
   assign rsp_port.station_long_count  = out_slrc_ff;

   // insertion pass only runs after a scan that found no entry
   a_insert_no_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INSERT |-> !hit_ff)
      else $error("insert pass after a hit");

   // a full table and a missing entry never come from the same event
   a_full_missing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(out_full_ff && out_miss_ff))
      else $error("table_full with entry_missing");

   // a class limit hit needs a live count, which is at least one
   a_limit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_lim_ff |-> out_cnt_ff != 8'd0)
      else $error("limit_reached with zero count");

   // a missing entry reports no count
   a_missing_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_miss_ff |-> out_cnt_ff == 8'd0 && !out_lim_ff)
      else $error("entry_missing with a count");

   // at most one slot written per insertion pass, and only into a free one
   a_insert_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INSERT && ins_ff |-> $past(ins_ff) || $past(state_ff) == S_INSERT)
      else $error("insert flag set outside insertion pass");

endmodule

### rtl/wlan_qos_retry_counter_table_top.sv
// Top level of the 802.11 retry counter table: slot ring plus sequencer.
//
//  channel   dir  handshake            payload
//  req_port  in   valid/ready          action, tid, seq_num, frag_num, frame_length
//  rsp_port  out  valid/ready          cw_command, retry_count, flags, station counts
//  csr_*     in   csr_write_enable     csr_index (0 thr, 1 short lim, 2 long lim), data
//
// Each word takes one lap of the slot ring, which moves one slot per cycle past the
// head cell during the scan and insert passes; a failure that finds no entry while a
// free slot exists takes a second lap, which places the new entry.
// Reset clears the slot valid bits; there is no clearing pass.
// A finished word sits in the output register while the next word is taken; a word
// in progress waits at its end only while that register is still full.
module wlan_qos_retry_counter_table_top #(
   parameter int TABLE_ENTRIES = wqrc_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int COUNT_BITS    = wqrc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   wqrc_req_if.sink                            req_port,
   wqrc_rsp_if.source                          rsp_port,
   input  logic                                csr_write_enable,
   input  logic [wqrc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [wqrc_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   // slot: short valid, long valid, key, short count, long count
   localparam int SLOT_BITS = 2 + wqrc_pkg::KEY_BITS + 2 * COUNT_BITS;

   logic                 ring_shift;
   logic [SLOT_BITS-1:0] ring_head;
   logic [SLOT_BITS-1:0] chain [TABLE_ENTRIES+1];

   assign chain[0] = ring_head;

   // the cells form a shift line; the tail feeds back through the head logic
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      wqrc_cell #(
         .SLOT_BITS (SLOT_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (ring_shift),
         .slot_in  (chain[i]),
         .slot_out (chain[i+1])
      );
   end

   wqrc_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .COUNT_BITS    (COUNT_BITS),
      .SLOT_BITS     (SLOT_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_port),
      .rsp_port         (rsp_port),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .ring_tail        (chain[TABLE_ENTRIES]),
      .ring_head        (ring_head),
      .ring_shift       (ring_shift)
   );

endmodule
